FILE: src/psk_pkg.sv
package psk_pkg;

  localparam int unsigned ChannelBits = 8;
  localparam int unsigned KeyBits     = 16;
  localparam int unsigned ModeBits    = 4;

  // Divider widths: numerator and denominator each up to 6c (11 bits)
  localparam int unsigned NumBits = ChannelBits + 3;
  localparam int unsigned DenBits = ChannelBits + 3;
  // Quotient bits produced, one above the key width to catch saturation
  localparam int unsigned QuoBits = KeyBits + 1;

  localparam logic [ChannelBits-1:0] FullScale = {ChannelBits{1'b1}};
  localparam logic [ModeBits-1:0]    ModeReset = ModeBits'(9);

  typedef enum logic [ModeBits-1:0] {
    ModeRed    = 4'd0,
    ModeGreen  = 4'd1,
    ModeBlue   = 4'd2,
    ModeAvg    = 4'd3,
    ModeValue  = 4'd4,
    ModeMax    = 4'd5,
    ModeMin    = 4'd6,
    ModeChroma = 4'd7,
    ModeLight  = 4'd8,
    ModeHue    = 4'd9,
    ModeSatHsv = 4'd10,
    ModeSatHsl = 4'd11
  } key_mode_e;

  typedef logic [ChannelBits-1:0] chan_t;
  typedef logic [KeyBits-1:0]     key_t;

endpackage

FILE: src/psk_pixel_if.sv
interface psk_pixel_if;
  import psk_pkg::*;
  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;
  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

FILE: src/psk_key_if.sv
interface psk_key_if;
  import psk_pkg::*;
  logic valid;
  logic ready;
  key_t sort_key;
  modport source (output valid, output sort_key, input ready);
  modport sink   (input valid, input sort_key, output ready);
endinterface

FILE: src/psk_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Gives floor(num * 2^KeyBits / den) saturated, zero when den is zero.
module psk_div_pipe (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  logic [psk_pkg::NumBits-1:0] num_i,
  input  logic [psk_pkg::DenBits-1:0] den_i,
  output logic                       valid_o,
  output logic [psk_pkg::KeyBits-1:0] quo_o
);
  import psk_pkg::*;

  localparam int unsigned RemBits = DenBits + 1;

  // Stage registers; stage s+1 holds the result of quotient step s
  logic [QuoBits:1]              vld_q;
  logic [RemBits-1:0]            rem_q [1:QuoBits];
  logic [DenBits-1:0]            den_q [1:QuoBits];
  logic [QuoBits-1:0]            quo_q [1:QuoBits];

  for (genvar s = 0; s < QuoBits; s++) begin : g_stage
    logic               vld_in;
    logic [RemBits-1:0] rem_in;
    logic [DenBits-1:0] den_in;
    logic [QuoBits-1:0] quo_in;
    logic [RemBits-1:0] trial;
    logic               take;
    logic [RemBits-1:0] rem_d;
    logic [QuoBits-1:0] quo_d;

    if (s == 0) begin : g_first
      // the integer part (num/den) starts as remainder, tested unshifted;
      // num < 2*den always except den = 0, so one extra quotient bit suffices
      assign vld_in = valid_i;
      assign rem_in = RemBits'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
      assign trial  = rem_in;
    end else begin : g_next
      // later stages shift in a zero
      assign vld_in = vld_q[s];
      assign rem_in = rem_q[s];
      assign den_in = den_q[s];
      assign quo_in = quo_q[s];
      assign trial  = {rem_in[RemBits-2:0], 1'b0};
    end

    always_comb begin
      take  = trial >= RemBits'(den_in);
      rem_d = take ? trial - RemBits'(den_in) : trial;
      quo_d = {quo_in[QuoBits-2:0], take};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s+1] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s+1] <= rem_d;
        den_q[s+1] <= den_in;
        quo_q[s+1] <= quo_d;
      end
    end
  end

  assign valid_o = vld_q[QuoBits];
  // zero divisor gives zero; a quotient of one or more saturates to all ones
  always_comb begin
    if (den_q[QuoBits] == '0) begin
      quo_o = '0;
    end else if (quo_q[QuoBits][QuoBits-1]) begin
      quo_o = '1;
    end else begin
      quo_o = quo_q[QuoBits][KeyBits-1:0];
    end
  end

endmodule

FILE: src/pixel_sort_key_from_rgb.sv
// Stages: pixel register, operand stage, 17 divider stages, output register.
// Throughput: one pixel per cycle; the whole pipe holds while the output is stalled,
// so input ready follows output ready whenever the output register is full.
// Reset: asynchronous, active low; clears all valid bits and sets key_mode to hue.
// One restoring divider stage per quotient bit sets the depth.
module pixel_sort_key_from_rgb (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [psk_pkg::ModeBits-1:0] cfg_wdata_i,
  psk_pixel_if.sink                   pix,
  psk_key_if.source                   key
);
  import psk_pkg::*;

  logic [ModeBits-1:0] mode_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Pipe advances while the output slot is free or being emptied
  logic adv;
  logic out_vld_q;
  key_t out_key_q;
  logic div_vld;
  key_t div_quo;
  assign adv = !out_vld_q || key.ready;
  assign pix.ready = adv;

  // Stage 1: register the pixel
  logic  s1_vld_q;
  chan_t r_q, g_q, b_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= pix.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q <= pix.red_in;
      g_q <= pix.green_in;
      b_q <= pix.blue_in;
    end
  end

  // Max, min, and the ratio operands for the selected mode
  chan_t              mx, mn, c;
  logic [ChannelBits:0] s, d2;
  logic [NumBits-1:0] num_d;
  logic [DenBits-1:0] den_d;
  localparam logic [ChannelBits:0] TwoF = {FullScale, 1'b0};
  always_comb begin
    mx = r_q;
    if (g_q > mx) mx = g_q;
    if (b_q > mx) mx = b_q;
    mn = r_q;
    if (g_q < mn) mn = g_q;
    if (b_q < mn) mn = b_q;
    c  = mx - mn;
    s  = {1'b0, mx} + {1'b0, mn};
    d2 = (s < TwoF - s) ? s : TwoF - s;
    num_d = '0;
    den_d = '0;
    case (mode_q)
      ModeRed:    begin num_d = NumBits'(r_q); den_d = DenBits'(FullScale); end
      ModeGreen:  begin num_d = NumBits'(g_q); den_d = DenBits'(FullScale); end
      ModeBlue:   begin num_d = NumBits'(b_q); den_d = DenBits'(FullScale); end
      ModeAvg: begin
        num_d = NumBits'(r_q) + NumBits'(g_q) + NumBits'(b_q);
        den_d = DenBits'(FullScale) * DenBits'(3);
      end
      ModeValue, ModeMax: begin num_d = NumBits'(mx); den_d = DenBits'(FullScale); end
      ModeMin:    begin num_d = NumBits'(mn); den_d = DenBits'(FullScale); end
      ModeChroma: begin num_d = NumBits'(c); den_d = DenBits'(FullScale); end
      ModeLight:  begin num_d = NumBits'(s); den_d = DenBits'(TwoF); end
      ModeHue: begin
        den_d = DenBits'(c) * DenBits'(6);
        if (mx == r_q) begin
          num_d = (g_q >= b_q) ? NumBits'(g_q - b_q)
                               : NumBits'(den_d) - NumBits'(b_q - g_q);
        end else if (mx == g_q) begin
          num_d = NumBits'(b_q) + NumBits'({c, 1'b0}) - NumBits'(r_q);
        end else begin
          num_d = NumBits'(r_q) + NumBits'({c, 2'b00}) - NumBits'(g_q);
        end
      end
      ModeSatHsv: begin num_d = NumBits'(c); den_d = DenBits'(mx); end
      ModeSatHsl: begin
        num_d = NumBits'(c);
        den_d = (s == '0 || s == TwoF) ? '0 : DenBits'(d2);
      end
      default: begin num_d = '0; den_d = '0; end
    endcase
  end

  // Stage 2: register operands
  logic               s2_vld_q;
  logic [NumBits-1:0] num_q;
  logic [DenBits-1:0] den_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  psk_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s2_vld_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .valid_o (div_vld),
    .quo_o   (div_quo)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= div_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_key_q <= div_quo;
    end
  end
  assign key.valid    = out_vld_q;
  assign key.sort_key = out_key_q;

endmodule
